// File: src/bsq_pkg.sv
// shared types, constants and a helper for the byte set with successor query
`timescale 1ns / 1ps

package bsq_pkg;

  localparam int unsigned SEG_BITS    = 4;
  localparam int unsigned SEG_SIZE    = 1 << SEG_BITS;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned VALUE_W     = 8;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_MEMBER = 2'd2,
    KIND_LOWER  = 2'd3
  } kind_t;

  // control part of the token that walks the row of cells
  typedef struct packed {
    logic  valid;
    kind_t kind;
    logic  found;
    logic  changed;
  } tok_ctl_t;

  // position of the lowest set bit of one segment
  function automatic logic [SEG_BITS-1:0] lowest_set(input logic [SEG_SIZE-1:0] v);
    logic [SEG_BITS-1:0] r;
    r = '0;
    for (int i = SEG_SIZE - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = SEG_BITS'(i);
      end
    end
    return r;
  endfunction

endpackage

// File: src/byte_set_with_successor_query.sv
// top level: set of element values with add, remove, member and lower bound
//
//  channel | handshake           | tdata                                  | tuser
//  in_     | in_tvalid/in_tready  | [7:0] value                            | [1:0] kind
//  out_    | out_tvalid/out_tready| [7:0] result_value, [16:8] member_count| [0] found
//
// an item walks the row of 2^(ELEMENT_BITS-4) cells, one cell per cycle (16 by default),
// then waits in a result holding stage before the output register:
// out_tvalid rises once the result is loaded into the output register, one item in flight.
// in_tready returns once the result sits in the output register, so items do not overlap.
// reset (synchronous, rst_n low) empties the set and zeroes the count at once.
// a stalled output holds its item; the next result waits in the holding stage, in_tready low.
`timescale 1ns / 1ps

module byte_set_with_successor_query #(
  parameter int unsigned ELEMENT_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bsq_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] value
  input  logic [bsq_pkg::KIND_W-1:0]         in_tuser,   // [1:0] kind
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bsq_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [7:0] result_value, [16:8] member_count
  output logic [bsq_pkg::OUT_TUSER_W-1:0]    out_tuser   // [0] found
);
  import bsq_pkg::*;

  localparam int unsigned EW    = ELEMENT_BITS;
  localparam int unsigned NCELL = 1 << (EW - SEG_BITS);
  localparam int unsigned CW    = EW + 1;

  tok_ctl_t      ctl_c [NCELL+1];
  logic [EW-1:0] idx_c [NCELL+1];
  logic [EW-1:0] hit_c [NCELL+1];

  logic                busy_r, busy_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic                pend_found_r;
  logic [VALUE_W-1:0]  pend_value_r;
  logic [COUNT_W-1:0]  pend_count_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r;
  logic [VALUE_W-1:0]  out_value_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic     in_accept;
  logic     move;
  tok_ctl_t ctl_exit;

  assign in_tready = !busy_r;
  assign in_accept = in_tvalid && in_tready;

  assign ctl_c[0] = {in_accept, kind_t'(in_tuser), 1'b0, 1'b0};
  assign idx_c[0] = EW'(in_tdata);
  assign hit_c[0] = '0;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    bsq_cell #(
      .ELEMENT_BITS (EW),
      .CELL_IDX     (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_in  (ctl_c[k]),
      .idx_in  (idx_c[k]),
      .hit_in  (hit_c[k]),
      .ctl_out (ctl_c[k+1]),
      .idx_out (idx_c[k+1]),
      .hit_out (hit_c[k+1])
    );
  end

  assign ctl_exit = ctl_c[NCELL];
  assign move     = pend_valid_r && (!out_valid_r || out_tready);

  always_comb begin
    count_nxt = count_r;
    if (ctl_exit.valid && ctl_exit.changed) begin
      case (ctl_exit.kind)
        KIND_ADD:    count_nxt = count_r + CW'(1);
        KIND_REMOVE: count_nxt = count_r - CW'(1);
        default:     count_nxt = count_r;
      endcase
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (in_accept) begin
      busy_nxt = 1'b1;
    end else if (move) begin
      busy_nxt = 1'b0;
    end
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    if (ctl_exit.valid) begin
      pend_valid_nxt = 1'b1;
    end else if (move) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_exit.valid) begin
      pend_found_r <= ctl_exit.found;
      pend_value_r <= VALUE_W'(hit_c[NCELL]);
      pend_count_r <= COUNT_W'(count_nxt);
    end
    if (move) begin
      out_found_r <= pend_found_r;
      out_value_r <= pend_value_r;
      out_count_r <= pend_count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - COUNT_W - VALUE_W)'(0), out_count_r, out_value_r};
  assign out_tuser  = out_found_r;

endmodule

// File: src/bsq_cell.sv
// one cell of the row: a segment of the presence bitmap and a token stage
`timescale 1ns / 1ps

module bsq_cell #(
  parameter int unsigned ELEMENT_BITS = 8,
  parameter int unsigned CELL_IDX     = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bsq_pkg::tok_ctl_t       ctl_in,
  input  logic [ELEMENT_BITS-1:0] idx_in,
  input  logic [ELEMENT_BITS-1:0] hit_in,
  output bsq_pkg::tok_ctl_t       ctl_out,
  output logic [ELEMENT_BITS-1:0] idx_out,
  output logic [ELEMENT_BITS-1:0] hit_out
);
  import bsq_pkg::*;

  localparam int unsigned EW = ELEMENT_BITS;

  logic [SEG_SIZE-1:0] bits_r, bits_nxt;
  tok_ctl_t            ctl_r, ctl_nxt;
  logic [EW-1:0]       idx_r;
  logic [EW-1:0]       hit_r, hit_nxt;

  logic [EW-1:0]       seg_in;
  logic [EW-1:0]       my_seg;
  logic [EW-1:0]       base;
  logic                mine;
  logic                above;
  logic [SEG_BITS-1:0] pos;
  logic                bit_cur;
  logic [SEG_SIZE-1:0] cand;
  logic [SEG_BITS-1:0] low_pos;

  assign seg_in  = idx_in >> SEG_BITS;
  assign my_seg  = EW'(CELL_IDX);
  assign base    = my_seg << SEG_BITS;
  assign mine    = (seg_in == my_seg);
  assign above   = (my_seg > seg_in);
  assign pos     = idx_in[SEG_BITS-1:0];
  assign bit_cur = bits_r[pos];
  assign cand    = mine ? (bits_r & ({SEG_SIZE{1'b1}} << pos)) : (above ? bits_r : '0);
  assign low_pos = lowest_set(cand);

  always_comb begin
    bits_nxt = bits_r;
    ctl_nxt  = ctl_in;
    hit_nxt  = hit_in;
    if (ctl_in.valid) begin
      case (ctl_in.kind)
        KIND_ADD: begin
          if (mine && !bit_cur) begin
            bits_nxt[pos]   = 1'b1;
            ctl_nxt.changed = 1'b1;
          end
        end
        KIND_REMOVE: begin
          if (mine && bit_cur) begin
            bits_nxt[pos]   = 1'b0;
            ctl_nxt.changed = 1'b1;
            ctl_nxt.found   = 1'b1;
          end
        end
        KIND_MEMBER: begin
          if (mine) begin
            ctl_nxt.found = bit_cur;
          end
        end
        KIND_LOWER: begin
          if (!ctl_in.found && (cand != '0)) begin
            ctl_nxt.found = 1'b1;
            hit_nxt       = base | EW'(low_pos);
          end
        end
        default: begin
          ctl_nxt = ctl_in;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
      ctl_r  <= '0;
    end else begin
      bits_r <= bits_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_in;
    hit_r <= hit_nxt;
  end

  assign ctl_out = ctl_r;
  assign idx_out = idx_r;
  assign hit_out = hit_r;

endmodule
